[design/led_gamma_brightness_limiter_top_assert.svh]
// Assertion macros shared by the checker of the LED gamma/brightness limiter.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef LED_GAMMA_BRIGHTNESS_LIMITER_TOP_ASSERT_SVH
`define LED_GAMMA_BRIGHTNESS_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LGBL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lgbl checker: same-cycle property failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LGBL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lgbl checker: next-cycle property failed");

`endif

[design/lgbl_pkg.sv]
// Shared widths, codes and lane control types of the LED gamma/brightness limiter.
// No dependencies.
`timescale 1ns / 1ps

package lgbl_pkg;

  localparam int CH_W       = 8;   // one color channel / table entry
  localparam int BRIGHT_W   = 9;   // brightness register
  localparam int LEN_W      = 13;  // strip length register
  localparam int CFG_W      = 13;  // widest register
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = 21;  // n*b, n <= 8191, b <= 256
  localparam int DEN_W      = PROD_W + 1;  // 2*n*b
  localparam int NUM_W      = 23;  // 20480*v + n*b
  localparam int QUO_W      = 8;
  localparam int DIV_STEPS  = QUO_W;
  localparam int DIV_FIRST  = 3;   // first divider stage index
  localparam int NSTG       = DIV_FIRST + DIV_STEPS;
  localparam int DSH_W      = DEN_W + DIV_STEPS - 1;
  localparam int N_LANES    = 3;
  localparam int MUL_W      = CH_W + BRIGHT_W;
  localparam int NUM_SH_HI  = 14;  // 20480 = 2^14 + 2^12
  localparam int NUM_SH_LO  = 12;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int PIX_OFS    = 16;  // red starts here in s_axis_tdata

  localparam logic [BRIGHT_W-1:0] FULL_BRIGHT = 9'd256;
  localparam logic [PROD_W-1:0]   LIMIT_PROD  = 21'd10240;  // 2400*256/60
  localparam logic [MUL_W-1:0]    ROUND_HALF  = 17'd128;

  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAFETY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN    = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic [NSTG-1:0]     ld;       // per-stage load enables
    logic                wr_en;    // gamma table write
    logic [CH_W-1:0]     wr_addr;
    logic [CH_W-1:0]     wr_data;
    logic [BRIGHT_W-1:0] bright;   // saturated brightness
    logic [PROD_W-1:0]   dprod;    // n*b
    logic [DEN_W-1:0]    den;      // 2*n*b
  } lane_ctrl_t;

  typedef struct packed {
    logic [CH_W-1:0]  dim;
    logic [QUO_W-1:0] quo;
  } lane_res_t;

endpackage

[design/lgbl_lane.sv]
// One color lane: private gamma table copy, dimming multiply and an
// 8-step pipelined restoring divider for the current-limit scale. Uses lgbl_pkg.
`timescale 1ns / 1ps

module lgbl_lane (
  input  logic                      clk_i,
  input  lgbl_pkg::lane_ctrl_t      ctrl_i,
  input  logic [lgbl_pkg::CH_W-1:0] ch_i,
  output lgbl_pkg::lane_res_t       res_o
);

  localparam int NSTG  = lgbl_pkg::NSTG;
  localparam int DF    = lgbl_pkg::DIV_FIRST;
  localparam int STEPS = lgbl_pkg::DIV_STEPS;

  logic [lgbl_pkg::CH_W-1:0]  mem [256];
  logic [lgbl_pkg::CH_W-1:0]  gam_q;
  logic [lgbl_pkg::CH_W-1:0]  dim_q [1:NSTG-1];
  logic [lgbl_pkg::NUM_W-1:0] rem_q [DF-1:NSTG-1];
  logic [lgbl_pkg::QUO_W-1:0] quo_q [DF-1:NSTG-1];

  logic [lgbl_pkg::MUL_W-1:0]  prod;
  logic [lgbl_pkg::CH_W-1:0]   dim_d;
  logic [lgbl_pkg::NUM_W-1:0]  num_d;
  logic [lgbl_pkg::DSH_W-1:0]  dsh  [STEPS];
  logic                        ge   [STEPS];
  logic [lgbl_pkg::NUM_W-1:0]  rem_d [STEPS];
  logic [lgbl_pkg::QUO_W-1:0]  quo_d [STEPS];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.wr_addr] <= ctrl_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld[0]) begin
      gam_q <= mem[ch_i];
    end
  end

  // round half up of gamma*b/256
  always_comb begin
    prod  = lgbl_pkg::MUL_W'(gam_q) * lgbl_pkg::MUL_W'(ctrl_i.bright) + lgbl_pkg::ROUND_HALF;
    dim_d = prod[15:8];
  end

  // numerator 2*v*10240 + d as shift-add
  always_comb begin
    num_d = (lgbl_pkg::NUM_W'(dim_q[1]) << lgbl_pkg::NUM_SH_HI)
          + (lgbl_pkg::NUM_W'(dim_q[1]) << lgbl_pkg::NUM_SH_LO)
          + lgbl_pkg::NUM_W'(ctrl_i.dprod);
  end

  // one quotient bit per stage, MSB first
  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      dsh[k]   = lgbl_pkg::DSH_W'(ctrl_i.den) << (STEPS - 1 - k);
      ge[k]    = lgbl_pkg::DSH_W'(rem_q[DF+k-1]) >= dsh[k];
      rem_d[k] = ge[k] ? rem_q[DF+k-1] - dsh[k][lgbl_pkg::NUM_W-1:0] : rem_q[DF+k-1];
      quo_d[k] = {quo_q[DF+k-1][lgbl_pkg::QUO_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld[1]) begin
      dim_q[1] <= dim_d;
    end
    if (ctrl_i.ld[DF-1]) begin
      rem_q[DF-1] <= num_d;
      quo_q[DF-1] <= '0;
    end
    for (int i = 2; i < NSTG; i++) begin
      if (ctrl_i.ld[i]) begin
        dim_q[i] <= dim_q[i-1];
      end
    end
    for (int k = 0; k < STEPS; k++) begin
      if (ctrl_i.ld[DF+k]) begin
        rem_q[DF+k] <= rem_d[k];
        quo_q[DF+k] <= quo_d[k];
      end
    end
  end

  assign res_o.dim = dim_q[NSTG-1];
  assign res_o.quo = quo_q[NSTG-1];

endmodule

[design/lgbl_merge.sv]
// Output stage: picks dimmed or limited value per lane and holds the result
// item for the master side. Uses lgbl_pkg.
`timescale 1ns / 1ps

module lgbl_merge (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  input  lgbl_pkg::lane_res_t [lgbl_pkg::N_LANES-1:0]      res_i,
  input  logic                                             limit_i,
  output logic                                             ready_o,
  output logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  output logic [lgbl_pkg::OUT_DATA_W-1:0]                  m_axis_tdata,
  output logic                                             m_axis_tuser
);

  logic                               valid_q;
  logic [lgbl_pkg::OUT_DATA_W-1:0]    data_q, data_d;
  logic                               flag_q;

  assign ready_o = !valid_q || m_axis_tready;

  // quotient never exceeds 255 while limiting, so no clamp is needed
  always_comb begin
    for (int l = 0; l < lgbl_pkg::N_LANES; l++) begin
      data_d[l*lgbl_pkg::CH_W +: lgbl_pkg::CH_W] = limit_i ? res_i[l].quo : res_i[l].dim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
      flag_q <= limit_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = flag_q;

endmodule

[design/led_gamma_brightness_limiter_top.sv]
// Top level of the LED gamma/brightness limiter: config registers, pipeline
// valid chain, three color lanes and the output merge. Uses lgbl_pkg,
// lgbl_lane and lgbl_merge.
`timescale 1ns / 1ps

// Pixel path for an addressable LED strip. Items on s_axis are either gamma
// table writes (tuser = 0, no result) or pixels (tuser = 1, one result on
// m_axis). Each pixel channel is looked up in the gamma table, dimmed by
// brightness/256 with rounding half up and, when safety is on and
// strip_length*brightness exceeds 10240 (60 mA per LED against a 2.4 A rail),
// rescaled to round(v*10240/(n*b)); m_axis_tuser flags that case. The block
// sustains one item per cycle while m_axis is not stalled; a pixel passes
// twelve register stages, the first loaded at the edge that accepts it: table
// read, dimming multiply, numerator, the eight steps of each lane's pipelined
// restoring divider and the output register. Each of the three lanes keeps
// its own 256x8 copy of the table, written by every table write, so all
// channels read in the same cycle. The table comes up undefined and there is
// no clearing pass: write an entry before a pixel uses it. Stalls on m_axis
// squeeze out pipeline bubbles before s_axis_tready drops. Configuration is
// taken on any cycle with cfg_we_i high and must only change while no pixel
// is in flight.
module led_gamma_brightness_limiter_top #(
  parameter int unsigned MAX_LEDS = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port, no read-back
  input  logic                                cfg_we_i,
  input  logic [lgbl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lgbl_pkg::CFG_W-1:0]          cfg_wdata_i,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] entry_index, [15:8] entry_value, [23:16] red_in,
  // [31:24] green_in, [39:32] blue_in
  input  logic [lgbl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] op
  input  logic                                s_axis_tuser,
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  output logic [lgbl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [0] limiting_active
  output logic                                m_axis_tuser
);

  localparam int NSTG = lgbl_pkg::NSTG;
  localparam int unsigned LenMax = (1 << lgbl_pkg::LEN_W) - 1;
  localparam int unsigned MaxLenSat = (MAX_LEDS > LenMax) ? LenMax : MAX_LEDS;
  localparam logic [lgbl_pkg::LEN_W-1:0] MaxLen = MaxLenSat[lgbl_pkg::LEN_W-1:0];

  logic [lgbl_pkg::BRIGHT_W-1:0] bright_q;
  logic                          safety_q;
  logic [lgbl_pkg::LEN_W-1:0]    len_q;
  logic [lgbl_pkg::PROD_W-1:0]   dprod_q, dprod_d;

  logic [lgbl_pkg::BRIGHT_W-1:0] b_sat;
  logic [lgbl_pkg::LEN_W-1:0]    n_sat;
  logic                          limit;

  logic [NSTG-1:0]               v_q;
  logic [NSTG-1:0]               ld;
  logic                          merge_ready;
  logic                          in_acc;

  lgbl_pkg::lane_ctrl_t                          ctrl;
  lgbl_pkg::lane_res_t [lgbl_pkg::N_LANES-1:0]   res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= lgbl_pkg::FULL_BRIGHT;
      safety_q <= 1'b1;
      len_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lgbl_pkg::REG_BRIGHT: bright_q <= cfg_wdata_i[lgbl_pkg::BRIGHT_W-1:0];
        lgbl_pkg::REG_SAFETY: safety_q <= cfg_wdata_i[0];
        lgbl_pkg::REG_LEN:    len_q    <= cfg_wdata_i[lgbl_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate, then n*b for the current estimate (registered once)
  always_comb begin
    b_sat   = (bright_q > lgbl_pkg::FULL_BRIGHT) ? lgbl_pkg::FULL_BRIGHT : bright_q;
    n_sat   = (32'(len_q) > 32'(MaxLenSat)) ? MaxLen : len_q;
    dprod_d = lgbl_pkg::PROD_W'(n_sat) * lgbl_pkg::PROD_W'(b_sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dprod_q <= '0;
    end else begin
      dprod_q <= dprod_d;
    end
  end

  // d*60 > 2400*256 reduces to d > 10240
  assign limit = safety_q && (dprod_q > lgbl_pkg::LIMIT_PROD);

  // a stage loads when empty or when its content moves on
  always_comb begin
    ld[NSTG-1] = !v_q[NSTG-1] || merge_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      ld[i] = !v_q[i] || ld[i+1];
    end
  end

  assign s_axis_tready = ld[0];
  assign in_acc        = s_axis_tvalid && ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) begin
        v_q[0] <= in_acc && (s_axis_tuser == lgbl_pkg::OP_PIXEL);
      end
      for (int i = 1; i < NSTG; i++) begin
        if (ld[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  always_comb begin
    ctrl.ld      = ld;
    ctrl.wr_en   = in_acc && (s_axis_tuser == lgbl_pkg::OP_WRITE);
    ctrl.wr_addr = s_axis_tdata[0 +: lgbl_pkg::CH_W];
    ctrl.wr_data = s_axis_tdata[lgbl_pkg::CH_W +: lgbl_pkg::CH_W];
    ctrl.bright  = b_sat;
    ctrl.dprod   = dprod_q;
    ctrl.den     = {dprod_q, 1'b0};
  end

  for (genvar l = 0; l < lgbl_pkg::N_LANES; l++) begin : g_lane
    lgbl_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .ch_i   (s_axis_tdata[lgbl_pkg::PIX_OFS + l*lgbl_pkg::CH_W +: lgbl_pkg::CH_W]),
      .res_o  (res[l])
    );
  end

  lgbl_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (v_q[NSTG-1]),
    .res_i         (res),
    .limit_i       (limit),
    .ready_o       (merge_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[design/lgbl_checker.sv]
// Port-level checker for the LED gamma/brightness limiter, bound to the top.
// Uses lgbl_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "led_gamma_brightness_limiter_top_assert.svh"

module lgbl_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [lgbl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input logic                               m_axis_tuser
);

  // pipeline stages plus the output register
  localparam int CAP = lgbl_pkg::NSTG + 1;
  localparam int PW  = $clog2(CAP + 1);
  localparam logic [PW-1:0] CapV = PW'(CAP);

  logic [PW-1:0] pend_q;
  logic          pix_acc;
  logic          out_acc;

  assign pix_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == lgbl_pkg::OP_PIXEL);
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // pixels accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (pix_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !pix_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  `LGBL_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `LGBL_ASSERT_IMP(a_no_invented, m_axis_tvalid, pend_q != '0)
  `LGBL_ASSERT_IMP(a_full_stalls, (pend_q == CapV) && !m_axis_tready, !s_axis_tready)

endmodule

bind led_gamma_brightness_limiter_top lgbl_checker u_lgbl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
